// ----- rtl/ilda_header_sync_parser_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ilda header sync parser assertion macros
// shared property wrappers, clocked on clk_i and quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ILDA_HEADER_SYNC_PARSER_UNIT_DEFINES_SVH
`define ILDA_HEADER_SYNC_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define ILDA_HSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ilda_hsp same-cycle check failed");

// next-cycle implication
`define ILDA_HSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ilda_hsp next-cycle check failed");

`endif

// ----- rtl/ilda_hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ilda_hsp_pkg
// types, stage codes and magic letters of the ilda header parser
// ----------------------------------------------------------------------------
package ilda_hsp_pkg;

  localparam int unsigned STAGE_W = 3;
  localparam int unsigned FIELD_W = 4;

  // parser stages
  localparam logic [STAGE_W-1:0] ST_HUNT = 3'd0;
  localparam logic [STAGE_W-1:0] ST_M1   = 3'd1;
  localparam logic [STAGE_W-1:0] ST_M2   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_M3   = 3'd3;
  localparam logic [STAGE_W-1:0] ST_FMT  = 3'd4;
  localparam logic [STAGE_W-1:0] ST_NAME = 3'd5;
  localparam logic [STAGE_W-1:0] ST_REST = 3'd6;

  // result status codes
  localparam logic [1:0] STATUS_FULL   = 2'd0;
  localparam logic [1:0] STATUS_BROKEN = 2'd1;
  localparam logic [1:0] STATUS_EARLY  = 2'd2;

  localparam logic [31:0] COUNT_MAX  = 32'hffff_ffff;
  localparam logic [31:0] SKIP_BIAS  = 32'd8;
  localparam logic [31:0] NAME_BIAS  = 32'd4;
  localparam logic [31:0] MAX_FORMAT = 32'd5;

  localparam int unsigned DATA_W = 232;

  typedef struct packed {
    logic       eos;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] skipped_count;
    logic [7:0]  future_byte;
    logic [7:0]  scanner_byte;
    logic [15:0] total_frames;
    logic [15:0] identity;
    logic [15:0] quantity;
    logic [63:0] owner_bytes;
    logic [63:0] name_bytes;
    logic [2:0]  format_code;
    logic [1:0]  status;
  } result_t;

  function automatic logic [7:0] magic_char(input logic mode, input logic [1:0] idx);
    logic [7:0] c;
    unique case ({mode, idx})
      3'b000:  c = 8'h49; // I
      3'b001:  c = 8'h4c; // L
      3'b010:  c = 8'h44; // D
      3'b011:  c = 8'h41; // A
      3'b100:  c = 8'h43; // C
      3'b101:  c = 8'h52; // R
      3'b110:  c = 8'h54; // T
      default: c = 8'h4e; // N
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ilda_hsp_in_stage.sv -----
// ----------------------------------------------------------------------------
// ilda_hsp_in_stage
// input register holding one byte item until the parser takes it
// ----------------------------------------------------------------------------
module ilda_hsp_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  ilda_hsp_pkg::item_t  item_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output ilda_hsp_pkg::item_t  item_o
);
  import ilda_hsp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/ilda_hsp_core.sv -----
// ----------------------------------------------------------------------------
// ilda_hsp_core
// parser state and per-byte next-state logic, one byte per fire
// ----------------------------------------------------------------------------
`include "ilda_header_sync_parser_unit_defines.svh"

module ilda_hsp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  ilda_hsp_pkg::item_t   item_i,
  input  logic                  mode_i,
  output logic                  res_valid_o,
  output ilda_hsp_pkg::result_t res_o
);
  import ilda_hsp_pkg::*;

  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [FIELD_W-1:0] field_q, field_d;
  logic [31:0]        fmt_q, fmt_d;
  logic [63:0]        name_q, name_d;
  logic [63:0]        owner_q, owner_d;
  logic [15:0]        qty_q, qty_d;
  logic [15:0]        ident_q, ident_d;
  logic [15:0]        total_q, total_d;
  logic [7:0]         scan_q, scan_d;
  logic [31:0]        cons_q, cons_d;
  logic [31:0]        skip_q, skip_d;

  logic [7:0]  b;
  logic [31:0] cons_inc;
  logic [31:0] fmt_new;
  logic [63:0] name_new;
  logic [31:0] w0_less;
  logic [31:0] w1_x3;
  logic        fmt_ok;
  logic        broken;
  logic        done_full;
  logic        done_broken;

  assign b        = item_i.in_byte;
  assign cons_inc = (cons_q != COUNT_MAX) ? cons_q + 32'd1 : cons_q;
  assign fmt_new  = {fmt_q[23:0], b};
  assign name_new = {name_q[55:0], b};
  assign w0_less  = name_new[63:32] - NAME_BIAS;
  assign w1_x3    = {name_new[30:0], 1'b0} + name_new[31:0];
  assign broken   = !mode_i && (w0_less == w1_x3);
  assign fmt_ok   = mode_i ? (fmt_new == 32'd0) : (fmt_new <= MAX_FORMAT);

  always_comb begin
    stage_d     = stage_q;
    field_d     = field_q;
    fmt_d       = fmt_q;
    name_d      = name_q;
    owner_d     = owner_q;
    qty_d       = qty_q;
    ident_d     = ident_q;
    total_d     = total_q;
    scan_d      = scan_q;
    cons_d      = cons_inc;
    skip_d      = skip_q;
    done_full   = 1'b0;
    done_broken = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (stage_q)
      ST_M1, ST_M2, ST_M3: begin
        if (b == magic_char(mode_i, stage_q[1:0])) begin
          stage_d = stage_q + 3'd1;
          if (stage_q == ST_M3) begin
            field_d = '0;
            fmt_d   = '0;
          end
        end else begin
          stage_d = ST_HUNT;
        end
      end
      ST_FMT: begin
        fmt_d   = fmt_new;
        field_d = field_q + 4'd1;
        if (field_q >= 4'd3) begin
          field_d = '0;
          if (fmt_ok) begin
            skip_d  = (cons_inc == COUNT_MAX) ? COUNT_MAX : cons_inc - SKIP_BIAS;
            name_d  = '0;
            owner_d = '0;
            qty_d   = '0;
            ident_d = '0;
            total_d = '0;
            scan_d  = '0;
            stage_d = ST_NAME;
          end else begin
            stage_d = ST_HUNT;
          end
        end
      end
      ST_NAME: begin
        name_d  = name_new;
        field_d = field_q + 4'd1;
        if (field_q >= 4'd7) begin
          if (broken) begin
            qty_d       = name_new[15:0];
            done_broken = 1'b1;
          end else begin
            stage_d = ST_REST;
            field_d = '0;
          end
        end
      end
      ST_REST: begin
        field_d = field_q + 4'd1;
        priority if (field_q < 4'd8) begin
          owner_d = {owner_q[55:0], b};
        end else if (field_q < 4'd10) begin
          qty_d = {qty_q[7:0], b};
        end else if (field_q < 4'd12) begin
          ident_d = {ident_q[7:0], b};
        end else if (field_q < 4'd14) begin
          total_d = {total_q[7:0], b};
        end else if (field_q == 4'd14) begin
          scan_d = b;
        end else begin
          done_full = 1'b1;
        end
      end
      default: begin
        stage_d = (b == magic_char(mode_i, 2'd0)) ? ST_M1 : ST_HUNT;
      end
    endcase

    if (done_broken) begin
      res_valid_o       = 1'b1;
      res_o.status      = STATUS_BROKEN;
      res_o.format_code = fmt_q[2:0];
      res_o.name_bytes  = name_new;
      res_o.quantity    = name_new[15:0];
      res_o.skipped_count = skip_q;
    end else if (done_full) begin
      res_valid_o         = 1'b1;
      res_o.status        = STATUS_FULL;
      res_o.format_code   = fmt_q[2:0];
      res_o.name_bytes    = name_q;
      res_o.owner_bytes   = owner_q;
      res_o.quantity      = qty_q;
      res_o.identity      = ident_q;
      res_o.total_frames  = total_q;
      res_o.scanner_byte  = scan_q;
      res_o.future_byte   = b;
      res_o.skipped_count = skip_q;
    end else if (item_i.eos) begin
      res_valid_o         = 1'b1;
      res_o.status        = STATUS_EARLY;
      res_o.skipped_count = cons_inc;
    end

    // start afresh after any result
    if (res_valid_o) begin
      stage_d = ST_HUNT;
      field_d = '0;
      fmt_d   = '0;
      cons_d  = '0;
      skip_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_HUNT;
      field_q <= '0;
      fmt_q   <= '0;
      name_q  <= '0;
      owner_q <= '0;
      qty_q   <= '0;
      ident_q <= '0;
      total_q <= '0;
      scan_q  <= '0;
      cons_q  <= '0;
      skip_q  <= '0;
    end else if (fire_i) begin
      stage_q <= stage_d;
      field_q <= field_d;
      fmt_q   <= fmt_d;
      name_q  <= name_d;
      owner_q <= owner_d;
      qty_q   <= qty_d;
      ident_q <= ident_d;
      total_q <= total_d;
      scan_q  <= scan_d;
      cons_q  <= cons_d;
      skip_q  <= skip_d;
    end
  end

  `ILDA_HSP_ASSERT_NEXT(a_restart_after_result, fire_i && res_valid_o,
                        stage_q == ST_HUNT && cons_q == 32'd0 && field_q == 4'd0)
  `ILDA_HSP_ASSERT_NOW(a_fmt_index_range, stage_q == ST_FMT, field_q < 4'd4)
  `ILDA_HSP_ASSERT_NOW(a_name_index_range, stage_q == ST_NAME, field_q < 4'd8)
  `ILDA_HSP_ASSERT_NEXT(a_idle_holds_state, !fire_i, $stable(stage_q) && $stable(cons_q))

endmodule

// ----- rtl/ilda_hsp_out_stage.sv -----
// ----------------------------------------------------------------------------
// ilda_hsp_out_stage
// result register, holds one finished item until the sink takes it
// ----------------------------------------------------------------------------
module ilda_hsp_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ilda_hsp_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ilda_hsp_pkg::result_t res_o
);
  import ilda_hsp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/ilda_header_sync_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ilda_header_sync_parser_unit
// byte-serial parser for ilda section headers and crtn container headers
// ----------------------------------------------------------------------------
// Takes one byte per clock, sustained while results drain, and hands back one
// result item per completed or broken header or per early end of stream. A byte
// goes into an input register, is folded into the parser state by combinational
// logic, and any result lands in an output register, so both registers lie
// between an accepted byte and its result. The state update of the parser sets
// the rate of one byte a cycle; a stalled result costs throughput only once the
// input register is also full. container_mode should only be written while idle.
// ----------------------------------------------------------------------------
module ilda_header_sync_parser_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i,     // container_mode
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i, // in_byte
  input  logic                            s_axis_tlast_i, // end_of_stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // format_code, name_bytes, owner_bytes, quantity, identity, total_frames,
  // scanner_byte, future_byte, skipped_count, zero pad
  output logic [ilda_hsp_pkg::DATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]                      m_axis_tuser_o  // status
);
  import ilda_hsp_pkg::*;

  logic    mode_q, mode_d;
  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    out_free;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready_o = 1'b1;
  assign mode_d      = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign in_item.in_byte = s_axis_tdata_i;
  assign in_item.eos     = s_axis_tlast_i;
  assign advance         = stage_valid && out_free;

  ilda_hsp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  ilda_hsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (stage_item),
    .mode_i      (mode_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ilda_hsp_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.status;
  assign m_axis_tdata_o = {5'd0, out_res.skipped_count, out_res.future_byte,
                           out_res.scanner_byte, out_res.total_frames,
                           out_res.identity, out_res.quantity, out_res.owner_bytes,
                           out_res.name_bytes, out_res.format_code};

endmodule
